/* rtl/core/ndq_pkg.sv */
`default_nettype none

package ndq_pkg;

  // Default sizes of the rectangle table and of the coordinates.
  localparam int unsigned MAX_RECTS_DEF  = 16;
  localparam int unsigned COORD_BITS_DEF = 12;

  // Width of the reported distances; gaps saturate to this range.
  localparam int unsigned DIST_W = 14;

  // Item commands.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Direction slots of the minimum trackers.
  localparam int unsigned DIR_UP    = 0;
  localparam int unsigned DIR_RIGHT = 1;
  localparam int unsigned DIR_DOWN  = 2;
  localparam int unsigned DIR_LEFT  = 3;
  localparam int unsigned NUM_DIRS  = 4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_we;   // write the input rectangle into the table
    logic q_start;   // capture the query rectangle and clear the minima
    logic rd_en;     // read the next table entry
    logic out_load;  // move the minima into the result register
  } ndq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_zero;  // no active entries
    logic rd_last;   // the read being issued is the last active entry
    logic pipe_busy; // entries still in flight through the compare stages
  } ndq_sts_t;

endpackage

`default_nettype wire

/* rtl/core/ndq_ctrl.sv */
`default_nettype none

module ndq_ctrl
  import ndq_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire logic     command_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire ndq_sts_t sts_i,
  output ndq_cmd_t      cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_xfer;
  logic       slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  // The result register can take a new result when empty or being drained.
  assign slot_free   = !out_valid_q || out_ready_i;

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (command_i == CMD_LOAD) begin
            cmd_o.load_we = 1'b1;
          end else begin
            cmd_o.q_start = 1'b1;
            state_d = sts_i.cnt_zero ? ST_DONE : ST_RUN;
          end
        end
      end
      ST_RUN: begin
        cmd_o.rd_en = 1'b1;
        if (sts_i.rd_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result valid: set when a result is loaded, cleared when it is transferred.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A result is never taken while table entries are still in the compare stages.
  a_load_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !sts_i.pipe_busy)
    else $error("result loaded while compare pipeline busy");

  // A query with active entries always starts reading the table.
  a_query_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.q_start && !sts_i.cnt_zero) |=> cmd_o.rd_en)
    else $error("query did not start table walk");

  // A pending result is not overwritten before its transfer.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

endmodule

`default_nettype wire

/* rtl/core/ndq_datapath.sv */
`default_nettype none

module ndq_datapath
  import ndq_pkg::*;
#(
  parameter int unsigned MAX_RECTS  = MAX_RECTS_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1,
  localparam int unsigned CNT_W = $clog2(MAX_RECTS + 1)
)(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire ndq_cmd_t                cmd_i,
  output ndq_sts_t                     sts_o,
  input  wire logic                    cfg_we_i,
  input  wire logic [CNT_W-1:0]        cfg_data_i,
  input  wire logic [IDX_W-1:0]        entry_index_i,
  input  wire logic [COORD_BITS-1:0]   pos_x_i,
  input  wire logic [COORD_BITS-1:0]   pos_y_i,
  input  wire logic [COORD_BITS-1:0]   rect_w_i,
  input  wire logic [COORD_BITS-1:0]   rect_h_i,
  output logic signed [DIST_W-1:0]     dist_up_o,
  output logic signed [DIST_W-1:0]     dist_right_o,
  output logic signed [DIST_W-1:0]     dist_down_o,
  output logic signed [DIST_W-1:0]     dist_left_o,
  output logic                         found_up_o,
  output logic                         found_right_o,
  output logic                         found_down_o,
  output logic                         found_left_o
);

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned ENT_W = 4 * C;
  localparam int unsigned G_W   = C + 2;
  localparam int unsigned CMP_W = (G_W > DIST_W) ? G_W : DIST_W;
  localparam int          DIST_MIN = -(2 ** (DIST_W - 1));
  localparam int          DIST_MAX = (2 ** (DIST_W - 1)) - 1;
  localparam logic signed [CMP_W-1:0] SAT_MIN = CMP_W'(DIST_MIN);
  localparam logic signed [CMP_W-1:0] SAT_MAX = CMP_W'(DIST_MAX);

  // Active count register, saturated to the table depth on write.
  logic [CNT_W-1:0] active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cfg_we_i) begin
      active_q <= ((CNT_W + 1)'(cfg_data_i) > (CNT_W + 1)'(MAX_RECTS)) ?
                  CNT_W'(MAX_RECTS) : cfg_data_i;
    end
  end

  // Rectangle table: one write port for loads, one registered read port.
  logic [ENT_W-1:0] mem_q [MAX_RECTS];
  logic [ENT_W-1:0] rd_data_q;
  logic [CNT_W-1:0] cnt_q;
  logic             idx_ok;

  assign idx_ok = (IDX_W + 1)'(entry_index_i) < (IDX_W + 1)'(MAX_RECTS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && idx_ok) begin
      mem_q[entry_index_i] <= {pos_x_i, pos_y_i, rect_w_i, rect_h_i};
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[cnt_q[IDX_W-1:0]];
    end
  end

  // Query rectangle with its far edges precomputed.
  logic [C-1:0] qx_q, qy_q;
  logic [C:0]   qx2_q, qy2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_start) begin
      qx_q  <= pos_x_i;
      qy_q  <= pos_y_i;
      qx2_q <= (C + 1)'(pos_x_i) + (C + 1)'(rect_w_i);
      qy2_q <= (C + 1)'(pos_y_i) + (C + 1)'(rect_h_i);
    end
  end

  // Read counter and the valid bits of the two compare stages.
  logic rd_vld_q, gap_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      gap_vld_q <= 1'b0;
    end else begin
      if (cmd_i.q_start) begin
        cnt_q <= '0;
      end else if (cmd_i.rd_en) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      rd_vld_q  <= cmd_i.rd_en;
      gap_vld_q <= rd_vld_q;
    end
  end

  assign sts_o.cnt_zero  = (active_q == '0);
  assign sts_o.rd_last   = (cnt_q == active_q - CNT_W'(1));
  assign sts_o.pipe_busy = rd_vld_q || gap_vld_q;

  // Stage one: overlap tests and the vertical and horizontal gaps of one entry.
  logic [C-1:0]           rx, ry, rw, rh;
  logic [C:0]             rx2, ry2;
  logic                   ov_v_d, ov_h_d, below_d, right_d;
  logic signed [G_W-1:0]  gap_v_d, gap_h_d;
  logic                   ov_v_q, ov_h_q, below_q, right_q;
  logic signed [G_W-1:0]  gap_v_q, gap_h_q;

  always_comb begin
    {rx, ry, rw, rh} = rd_data_q;
    rx2     = (C + 1)'(rx) + (C + 1)'(rw);
    ry2     = (C + 1)'(ry) + (C + 1)'(rh);
    ov_v_d  = ((C + 1)'(rx) < qx2_q) && ((C + 1)'(qx_q) < rx2);
    ov_h_d  = ((C + 1)'(ry) < qy2_q) && ((C + 1)'(qy_q) < ry2);
    below_d = qy_q < ry;
    right_d = qx_q < rx;
    gap_v_d = below_d ? ($signed(G_W'(ry)) - $signed(G_W'(qy2_q)))
                      : ($signed(G_W'(qy_q)) - $signed(G_W'(ry2)));
    gap_h_d = right_d ? ($signed(G_W'(rx)) - $signed(G_W'(qx2_q)))
                      : ($signed(G_W'(qx_q)) - $signed(G_W'(rx2)));
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      ov_v_q  <= ov_v_d;
      ov_h_q  <= ov_h_d;
      below_q <= below_d;
      right_q <= right_d;
      gap_v_q <= gap_v_d;
      gap_h_q <= gap_h_d;
    end
  end

  // Stage two: keep the smallest gap per direction.
  logic [NUM_DIRS-1:0]   hit;
  logic signed [G_W-1:0] gap_sel [NUM_DIRS];
  logic signed [G_W-1:0] best_q [NUM_DIRS];
  logic [NUM_DIRS-1:0]   have_q;
  logic [NUM_DIRS-1:0]   take;

  always_comb begin
    hit[DIR_UP]        = ov_v_q && !below_q;
    hit[DIR_DOWN]      = ov_v_q && below_q;
    hit[DIR_RIGHT]     = ov_h_q && right_q;
    hit[DIR_LEFT]      = ov_h_q && !right_q;
    gap_sel[DIR_UP]    = gap_v_q;
    gap_sel[DIR_DOWN]  = gap_v_q;
    gap_sel[DIR_RIGHT] = gap_h_q;
    gap_sel[DIR_LEFT]  = gap_h_q;
    for (int k = 0; k < NUM_DIRS; k++) begin
      take[k] = gap_vld_q && hit[k] && (!have_q[k] || (gap_sel[k] < best_q[k]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= '0;
    end else if (cmd_i.q_start) begin
      have_q <= '0;
    end else begin
      have_q <= have_q | take;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_DIRS; k++) begin
      if (take[k]) begin
        best_q[k] <= gap_sel[k];
      end
    end
  end

  // Saturate the minima to the result width; a missing direction reads zero.
  logic signed [CMP_W-1:0]  ext [NUM_DIRS];
  logic signed [DIST_W-1:0] sat [NUM_DIRS];

  always_comb begin
    for (int k = 0; k < NUM_DIRS; k++) begin
      ext[k] = CMP_W'(best_q[k]);
      if (!have_q[k]) begin
        sat[k] = '0;
      end else if (ext[k] < SAT_MIN) begin
        sat[k] = DIST_W'(SAT_MIN);
      end else if (ext[k] > SAT_MAX) begin
        sat[k] = DIST_W'(SAT_MAX);
      end else begin
        sat[k] = DIST_W'(ext[k]);
      end
    end
  end

  // Result register.
  logic signed [DIST_W-1:0] dist_q [NUM_DIRS];
  logic [NUM_DIRS-1:0]      found_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      for (int k = 0; k < NUM_DIRS; k++) begin
        dist_q[k] <= sat[k];
      end
      found_q <= have_q;
    end
  end

  assign dist_up_o     = dist_q[DIR_UP];
  assign dist_right_o  = dist_q[DIR_RIGHT];
  assign dist_down_o   = dist_q[DIR_DOWN];
  assign dist_left_o   = dist_q[DIR_LEFT];
  assign found_up_o    = found_q[DIR_UP];
  assign found_right_o = found_q[DIR_RIGHT];
  assign found_down_o  = found_q[DIR_DOWN];
  assign found_left_o  = found_q[DIR_LEFT];

  // The table walk never reads past the active entries.
  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_en |-> (cnt_q < active_q))
    else $error("table read beyond active count");

  // Every query starts with no direction found.
  a_clear_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.q_start |=> (have_q == '0))
    else $error("minima not cleared at query start");

  // A found flag never rises without an entry in the second stage.
  a_found_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (have_q != $past(have_q) && !$past(cmd_i.q_start)) |-> $past(gap_vld_q))
    else $error("found flag set without a compared entry");

endmodule

`default_nettype wire

/* rtl/core/nearest_obstacle_distance_query.sv */
`default_nettype none

// Nearest obstacle distance query. A load item (command 0) writes one rectangle
// into the table in the cycle of its transfer and gives no result; a load whose
// entry_index is beyond the table is dropped. A query item (command 1) walks the
// first active_count table entries and returns one result: for each direction
// the smallest gap (negative when the rectangles overlap) and a found flag, with
// the distance reading zero when nothing was found. A query's result is ready
// once the walk through the single read port of the table, which delivers one
// entry per cycle, the two compare stages, the drain and the result load are
// done. With active_count at zero the query skips the walk and goes straight
// to the result load. A load leaves the block idle, so loads are taken back to
// back. The result sits in an output register, so loads and the next query are
// taken while it waits; a finished query waits only if the previous result has
// not been transferred. Table entries must be loaded before a query reads them.
// The user must write active_count through cfg_we_i only while the block is
// idle; the block itself does not enforce this. The written count is saturated
// to the table depth.

module nearest_obstacle_distance_query
  import ndq_pkg::*;
#(
  parameter int unsigned MAX_RECTS  = MAX_RECTS_DEF,
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  localparam int unsigned IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1,
  localparam int unsigned CNT_W = $clog2(MAX_RECTS + 1)
)(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CNT_W-1:0]      cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  command_i,
  input  wire logic [IDX_W-1:0]      entry_index_i,
  input  wire logic [COORD_BITS-1:0] pos_x_i,
  input  wire logic [COORD_BITS-1:0] pos_y_i,
  input  wire logic [COORD_BITS-1:0] rect_w_i,
  input  wire logic [COORD_BITS-1:0] rect_h_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic signed [DIST_W-1:0]   dist_up_o,
  output logic signed [DIST_W-1:0]   dist_right_o,
  output logic signed [DIST_W-1:0]   dist_down_o,
  output logic signed [DIST_W-1:0]   dist_left_o,
  output logic                       found_up_o,
  output logic                       found_right_o,
  output logic                       found_down_o,
  output logic                       found_left_o
);

  ndq_cmd_t cmd;
  ndq_sts_t sts;

  // Sequencer for loads, the table walk and the result handoff.
  ndq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Table, compare stages, minimum trackers and result register.
  ndq_datapath #(
    .MAX_RECTS  (MAX_RECTS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .entry_index_i (entry_index_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .rect_w_i      (rect_w_i),
    .rect_h_i      (rect_h_i),
    .dist_up_o     (dist_up_o),
    .dist_right_o  (dist_right_o),
    .dist_down_o   (dist_down_o),
    .dist_left_o   (dist_left_o),
    .found_up_o    (found_up_o),
    .found_right_o (found_right_o),
    .found_down_o  (found_down_o),
    .found_left_o  (found_left_o)
  );

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import ndq_pkg::*;

  localparam int unsigned COORD_W = COORD_BITS_DEF;
  localparam int unsigned IDX_W = $clog2(MAX_RECTS_DEF);
  localparam int unsigned CNT_W = $clog2(MAX_RECTS_DEF + 1);
  // A full table walk plus the compare stages and some margin.
  localparam int unsigned DRAIN_CYCLES = MAX_RECTS_DEF + 14;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_PER_PHASE = 290;
  localparam longint unsigned TIMEOUT_NS = 4_000_000;

  // One rectangle as the table stores it.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
  } rect_t;

  // One input item: a load or a query.
  typedef struct packed {
    logic               cmd;
    logic [IDX_W-1:0]   idx;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
  } item_t;

  // Nearest gap and found flag per direction, indexed by DIR_*.
  typedef struct packed {
    logic [NUM_DIRS-1:0][DIST_W-1:0] gap;
    logic [NUM_DIRS-1:0]             found;
  } gap_result_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [CNT_W-1:0]          cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic                      command_i = CMD_LOAD;
  logic [IDX_W-1:0]          entry_index_i = '0;
  logic [COORD_W-1:0]        pos_x_i = '0;
  logic [COORD_W-1:0]        pos_y_i = '0;
  logic [COORD_W-1:0]        rect_w_i = '0;
  logic [COORD_W-1:0]        rect_h_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [DIST_W-1:0]  dist_up_o;
  logic signed [DIST_W-1:0]  dist_right_o;
  logic signed [DIST_W-1:0]  dist_down_o;
  logic signed [DIST_W-1:0]  dist_left_o;
  logic                      found_up_o;
  logic                      found_right_o;
  logic                      found_down_o;
  logic                      found_left_o;

  // Mirror of the block's table and active count.
  rect_t             rect_mirror [MAX_RECTS_DEF];
  logic [CNT_W-1:0]  active_cnt = '0;

  gap_result_t       expected_gaps [$];
  int unsigned       mismatches = 0;
  int unsigned       loads_sent = 0;
  int unsigned       queries_sent = 0;
  int unsigned       results_checked = 0;
  int unsigned       found_seen [NUM_DIRS] = '{0, 0, 0, 0};
  int unsigned       tx_idle_pct = 0;
  int unsigned       rx_idle_pct = 0;
  int unsigned       rx_hold_requests = 0;
  string             dir_name [NUM_DIRS] = '{"up", "right", "down", "left"};

  nearest_obstacle_distance_query dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .entry_index_i (entry_index_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .rect_w_i      (rect_w_i),
    .rect_h_i      (rect_h_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .dist_up_o     (dist_up_o),
    .dist_right_o  (dist_right_o),
    .dist_down_o   (dist_down_o),
    .dist_left_o   (dist_left_o),
    .found_up_o    (found_up_o),
    .found_right_o (found_right_o),
    .found_down_o  (found_down_o),
    .found_left_o  (found_left_o)
  );

  // Free-running clock.
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Hard limit on the run length.
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout at %0t with %0d results outstanding", $time, expected_gaps.size());
    $display("Mismatches found");
    $finish;
  end

  // Keeps the smaller of the current best gap and a new one.
  function automatic void keep_nearer(inout int best, inout bit have, input int gap);
    if (!have || gap < best) begin
      best = gap;
      have = 1'b1;
    end
  endfunction

  // Walks the active entries of the mirrored table for one query rectangle.
  function automatic gap_result_t nearest_gaps(input item_t q);
    gap_result_t res;
    rect_t       r;
    int          best [NUM_DIRS];
    bit          have [NUM_DIRS];
    int          qx2, qy2, rx2, ry2, n, d;
    res = '0;
    for (int k = 0; k < NUM_DIRS; k++) begin
      best[k] = 0;
      have[k] = 1'b0;
    end
    n = (active_cnt > MAX_RECTS_DEF) ? MAX_RECTS_DEF : int'(active_cnt);
    qx2 = int'(q.x) + int'(q.w);
    qy2 = int'(q.y) + int'(q.h);
    for (int i = 0; i < n; i++) begin
      r = rect_mirror[i];
      rx2 = int'(r.x) + int'(r.w);
      ry2 = int'(r.y) + int'(r.h);
      // Open-interval overlap in x gives a vertical gap.
      if (int'(r.x) < qx2 && int'(q.x) < rx2) begin
        if (q.y < r.y) keep_nearer(best[DIR_DOWN], have[DIR_DOWN], int'(r.y) - qy2);
        else keep_nearer(best[DIR_UP], have[DIR_UP], int'(q.y) - ry2);
      end
      // Open-interval overlap in y gives a horizontal gap.
      if (int'(r.y) < qy2 && int'(q.y) < ry2) begin
        if (q.x < r.x) keep_nearer(best[DIR_RIGHT], have[DIR_RIGHT], int'(r.x) - qx2);
        else keep_nearer(best[DIR_LEFT], have[DIR_LEFT], int'(q.x) - rx2);
      end
    end
    // Saturate to the distance width; directions not found read zero.
    for (int k = 0; k < NUM_DIRS; k++) begin
      if (have[k]) begin
        d = best[k];
        if (d < -(1 << (DIST_W - 1))) d = -(1 << (DIST_W - 1));
        if (d > (1 << (DIST_W - 1)) - 1) d = (1 << (DIST_W - 1)) - 1;
        res.gap[k] = d[DIST_W-1:0];
        res.found[k] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic item_t rect_item(input logic cmd, input int unsigned idx,
                                      input int unsigned x, input int unsigned y,
                                      input int unsigned w, input int unsigned h);
    item_t it;
    it.cmd = cmd;
    it.idx = idx[IDX_W-1:0];
    it.x = x[COORD_W-1:0];
    it.y = y[COORD_W-1:0];
    it.w = w[COORD_W-1:0];
    it.h = h[COORD_W-1:0];
    return it;
  endfunction

  function automatic logic [COORD_W-1:0] extreme_coord();
    int unsigned pick;
    pick = $urandom_range(0, 2);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
  endfunction

  // Mostly clustered rectangles so that spans overlap often; some spread
  // over the whole plane and some at the coordinate extremes.
  function automatic item_t random_rect();
    item_t       it;
    int unsigned style;
    it = '0;
    style = $urandom_range(0, 99);
    if (style < 60) begin
      it.x = COORD_W'($urandom_range(1500, 2500));
      it.y = COORD_W'($urandom_range(1500, 2500));
      it.w = COORD_W'($urandom_range(0, 300));
      it.h = COORD_W'($urandom_range(0, 300));
    end else if (style < 85) begin
      it.x = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
      it.y = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
      it.w = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
      it.h = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
    end else begin
      it.x = extreme_coord();
      it.y = extreme_coord();
      it.w = extreme_coord();
      it.h = extreme_coord();
    end
    return it;
  endfunction

  task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // Offers one item and waits for its transfer, then updates the mirror.
  task automatic send_item(input item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= it.cmd;
    entry_index_i <= it.idx;
    pos_x_i       <= it.x;
    pos_y_i       <= it.y;
    rect_w_i      <= it.w;
    rect_h_i      <= it.h;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (it.cmd == CMD_LOAD) begin
      rect_mirror[it.idx] = '{x: it.x, y: it.y, w: it.w, h: it.h};
      loads_sent++;
    end else begin
      expected_gaps.insert(expected_gaps.size(), nearest_gaps(it));
      queries_sent++;
    end
  endtask

  // Stops offering items and waits until the block has gone quiet.
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (expected_gaps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_active_count(input logic [CNT_W-1:0] value);
    drain_block();
    cfg_data_i <= value;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    active_cnt = value;
    cfg_we_i   <= 1'b0;
  endtask

  // A query with the reset count of zero finds nothing.
  task automatic test_empty_table();
    set_idling(37, 76);
    send_item(rect_item(CMD_QUERY, 5, 100, 100, 50, 50));
  endtask

  // Fills every table entry; entry 0 is the reference box for the edge tests.
  task automatic test_load_table();
    for (int i = 0; i < MAX_RECTS_DEF; i++) begin
      if (i == 0) send_item(rect_item(CMD_LOAD, i, 100, 100, 50, 50));
      else if (i == 1) send_item(rect_item(CMD_LOAD, i, 0, 0, 0, 0));
      else if (i == MAX_RECTS_DEF - 1) send_item(rect_item(CMD_LOAD, i, 4095, 4095, 4095, 4095));
      else send_item(rect_item(CMD_LOAD, i, (i * 263) % 4096, (i * 517) % 4096,
                               16 + i * 37, 16 + i * 29));
    end
  endtask

  // One active entry: each direction, touching edges, zero width and overlap.
  task automatic test_single_entry_edges();
    write_active_count(1);
    send_item(rect_item(CMD_QUERY, 0, 120, 200, 10, 10));
    send_item(rect_item(CMD_QUERY, 15, 120, 20, 10, 10));
    send_item(rect_item(CMD_QUERY, 3, 150, 120, 10, 10));
    send_item(rect_item(CMD_QUERY, 12, 125, 300, 0, 0));
    send_item(rect_item(CMD_QUERY, 6, 100, 100, 50, 50));
    send_item(rect_item(CMD_QUERY, 9, 10, 110, 20, 5));
  endtask

  // Full table with extreme query rectangles, then a count above the table depth.
  task automatic test_full_table_extremes();
    write_active_count(MAX_RECTS_DEF);
    send_item(rect_item(CMD_QUERY, 0, 0, 0, 4095, 4095));
    send_item(rect_item(CMD_QUERY, 15, 4095, 4095, 0, 0));
    send_item(rect_item(CMD_QUERY, 7, 0, 4095, 4095, 0));
    write_active_count('1);
    send_item(rect_item(CMD_QUERY, 8, 2048, 2048, 100, 100));
  endtask

  // The receiver holds off for a long stretch while queries keep coming,
  // so the result register and the walk fill up and the input stalls.
  task automatic test_input_stall();
    item_t it;
    set_idling(0, 0);
    write_active_count(MAX_RECTS_DEF);
    rx_hold_requests++;
    for (int n = 0; n < 12; n++) begin
      it = random_rect();
      it.cmd = CMD_QUERY;
      it.idx = IDX_W'($urandom_range(0, MAX_RECTS_DEF - 1));
      send_item(it);
    end
  endtask

  // Random loads and queries over several table sizes and idle patterns.
  task automatic test_random_traffic();
    int unsigned counts [6];
    item_t       it;
    counts = '{16, 31, 7, 17, 1, 0};
    counts[5] = $urandom_range(0, MAX_RECTS_DEF);
    for (int p = 0; p < 6; p++) begin
      if (p < 2) set_idling(37, 76);
      else if (p < 4) set_idling(76, 37);
      else set_idling(0, 0);
      write_active_count(counts[p][CNT_W-1:0]);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        it = random_rect();
        it.idx = IDX_W'($urandom_range(0, MAX_RECTS_DEF - 1));
        it.cmd = ($urandom_range(0, 99) < 30) ? CMD_LOAD : CMD_QUERY;
        send_item(it);
      end
    end
  endtask

  // Result side: checks each transfer and drives ready with random stalls.
  always @(posedge clk_i) begin
    gap_result_t got;
    gap_result_t want;
    int unsigned hold_left;
    int unsigned hold_seen;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.gap[DIR_UP]      = dist_up_o;
      got.gap[DIR_RIGHT]   = dist_right_o;
      got.gap[DIR_DOWN]    = dist_down_o;
      got.gap[DIR_LEFT]    = dist_left_o;
      got.found[DIR_UP]    = found_up_o;
      got.found[DIR_RIGHT] = found_right_o;
      got.found[DIR_DOWN]  = found_down_o;
      got.found[DIR_LEFT]  = found_left_o;
      if (expected_gaps.size() == 0) begin
        mismatches++;
        $display("%0t: result transfer with no query outstanding", $time);
      end else begin
        want = expected_gaps.pop_front();
        results_checked++;
        for (int k = 0; k < NUM_DIRS; k++) begin
          if (got.found[k] !== want.found[k]) begin
            mismatches++;
            $display("%0t: found_%s expected %0b, got %0b", $time, dir_name[k],
                     want.found[k], got.found[k]);
          end
          if (got.gap[k] !== want.gap[k]) begin
            mismatches++;
            $display("%0t: dist_%s expected %0d, got %0d", $time, dir_name[k],
                     $signed(want.gap[k]), $signed(got.gap[k]));
          end
          if (want.found[k]) found_seen[k]++;
        end
      end
    end
    // A new hold request starts a long stretch with ready low.
    if (hold_seen != rx_hold_requests) begin
      hold_seen = rx_hold_requests;
      hold_left = RX_HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Reset, the tests in turn, then the verdict.
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_load_table();
    test_single_entry_edges();
    test_full_table_extremes();
    test_input_stall();
    test_random_traffic();
    drain_block();
    $display("Sent %0d loads and %0d queries over active counts 0 to 31, with idling",
             loads_sent, queries_sent);
    $display("on both sides and a long hold; checked %0d results, found u/r/d/l %0d/%0d/%0d/%0d",
             results_checked, found_seen[DIR_UP], found_seen[DIR_RIGHT],
             found_seen[DIR_DOWN], found_seen[DIR_LEFT]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
